>>> hdl/rtc_pkg.sv
// Shared types and codes for the range tag cache.
package rtc_pkg;

	// Default number of cache slots.
	localparam int SLOTS_DEF = 4;

	// Request function codes.
	localparam logic [1:0] FUNC_LOOKUP = 2'd0;
	localparam logic [1:0] FUNC_FILL   = 2'd1;
	localparam logic [1:0] FUNC_BURY   = 2'd2;
	localparam logic [1:0] FUNC_RSVD   = 2'd3;

	// Result status codes.
	typedef enum logic [2:0] {
		ST_HIT         = 3'd0,
		ST_MISS        = 3'd1,
		ST_FILL_STORED = 3'd2,
		ST_FILL_FAILED = 3'd3,
		ST_BURIED      = 3'd4,
		ST_NO_MATCH    = 3'd5,
		ST_NO_PENDING  = 3'd6
	} status_t;

endpackage

>>> hdl/range_tag_cache_lru.sv
// Range tag cache: a fully associative page cache with LRU replacement.
//
// A request word is taken into an input register; from there all slots compare against it in
// parallel, the recency ranks and slot contents update, and the result word lands in an output
// register. One request is accepted every cycle as long as the consumer takes results. The
// rate is set by the parallel range compare over the slot registers together with the rank
// update. A lookup miss empties the least recent slot and waits for a fill word; a fill with
// fill_ok set writes the page into that slot. A request with the unused function code is
// dropped without a result.
module range_tag_cache_lru #(
	parameter int SLOTS = rtc_pkg::SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  func,
	input  logic [63:0] address,
	input  logic [1:0]  addr_space,
	input  logic [31:0] page_size,
	input  logic        fill_ok,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [3:0]  slot_index,
	output logic [31:0] page_offset,
	output logic        release_needed,
	output logic [63:0] release_base,
	output logic [1:0]  release_space
);

	localparam int RW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam logic [RW-1:0] LRU_RANK = RW'(SLOTS - 1);

	// Input register.
	logic        s1_valid_q;
	logic [1:0]  func_s1;
	logic [63:0] address_s1;
	logic [1:0]  space_s1;
	logic [31:0] size_s1;
	logic        ok_s1;

	// Slot state.
	logic [63:0]   slot_base_q  [SLOTS];
	logic [1:0]    slot_space_q [SLOTS];
	logic [31:0]   slot_size_q  [SLOTS];
	logic [RW-1:0] rank_q       [SLOTS];
	logic          pend_valid_q;
	logic [RW-1:0] pend_slot_q;
	logic [63:0]   pend_addr_q;

	// Output register.
	logic          out_valid_q;
	rtc_pkg::status_t status_q;
	logic [3:0]    slot_index_q;
	logic [31:0]   page_offset_q;
	logic          release_needed_q;
	logic [63:0]   release_base_q;
	logic [1:0]    release_space_q;

	// Next-state and result values.
	logic [63:0]   diff      [SLOTS];
	logic [SLOTS-1:0] hit_vec;
	logic [SLOTS-1:0] lru_vec;
	logic          hit_any;
	logic [RW-1:0] hit_idx;
	logic [RW-1:0] lru_idx;
	logic [RW-1:0] tgt;
	logic          promote;
	logic          demote;
	logic [RW-1:0] tgt_rank;
	logic [RW-1:0] rank_d    [SLOTS];
	logic          size_clr;
	logic          slot_wr;
	logic          pend_set;
	logic          pend_clr;
	logic          produce;
	logic          adv;
	rtc_pkg::status_t res_status;
	logic [RW-1:0] res_idx;
	logic [31:0]   res_off;
	logic          res_rel;
	logic [63:0]   res_rbase;
	logic [1:0]    res_rspace;

	// Input moves on if the output register is free or emptying, or it gives no result.
	assign produce  = (func_s1 != rtc_pkg::FUNC_RSVD);
	assign adv      = s1_valid_q && (!produce || !out_valid_q || out_ready);
	assign in_ready = !s1_valid_q || adv;

	// Range compare of every slot and priority pick of the lowest hit.
	always_comb begin
		hit_any = 1'b0;
		hit_idx = '0;
		lru_idx = LRU_RANK;
		for (int i = 0; i < SLOTS; i++) begin
			diff[i]    = address_s1 - slot_base_q[i];
			hit_vec[i] = (slot_space_q[i] == space_s1) && (diff[i][63:32] == 32'd0)
				&& (diff[i][31:0] < slot_size_q[i]);
			lru_vec[i] = (rank_q[i] == LRU_RANK);
		end
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (hit_vec[i]) begin
				hit_any = 1'b1;
				hit_idx = RW'(i);
			end
			if (lru_vec[i]) begin
				lru_idx = RW'(i);
			end
		end
	end

	// Request decode and result formation.
	always_comb begin
		res_status = rtc_pkg::ST_HIT;
		res_idx    = '0;
		res_off    = '0;
		res_rel    = 1'b0;
		res_rbase  = '0;
		res_rspace = '0;
		tgt        = '0;
		promote    = 1'b0;
		demote     = 1'b0;
		size_clr   = 1'b0;
		slot_wr    = 1'b0;
		pend_set   = 1'b0;
		pend_clr   = 1'b0;
		unique case (func_s1)
			rtc_pkg::FUNC_LOOKUP: begin
				if (hit_any) begin
					res_status = rtc_pkg::ST_HIT;
					res_idx    = hit_idx;
					res_off    = diff[hit_idx][31:0];
					tgt        = hit_idx;
					promote    = 1'b1;
				end else begin
					res_status = rtc_pkg::ST_MISS;
					res_idx    = lru_idx;
					tgt        = lru_idx;
					if (slot_size_q[lru_idx] != 32'd0) begin
						res_rel    = 1'b1;
						res_rbase  = slot_base_q[lru_idx];
						res_rspace = slot_space_q[lru_idx];
					end
					size_clr = 1'b1;
					pend_set = 1'b1;
				end
			end
			rtc_pkg::FUNC_FILL: begin
				if (!pend_valid_q) begin
					res_status = rtc_pkg::ST_NO_PENDING;
				end else begin
					res_idx  = pend_slot_q;
					tgt      = pend_slot_q;
					pend_clr = 1'b1;
					if (ok_s1) begin
						res_status = rtc_pkg::ST_FILL_STORED;
						res_off    = pend_addr_q[31:0] - address_s1[31:0];
						slot_wr    = 1'b1;
						promote    = 1'b1;
					end else begin
						res_status = rtc_pkg::ST_FILL_FAILED;
						size_clr   = 1'b1;
					end
				end
			end
			rtc_pkg::FUNC_BURY: begin
				if (hit_any) begin
					res_status = rtc_pkg::ST_BURIED;
					res_idx    = hit_idx;
					tgt        = hit_idx;
					demote     = 1'b1;
				end else begin
					res_status = rtc_pkg::ST_NO_MATCH;
				end
			end
			default: begin
			end
		endcase
	end

	// Recency rank update: promote to most recent or demote to least recent.
	always_comb begin
		tgt_rank = rank_q[tgt];
		for (int i = 0; i < SLOTS; i++) begin
			rank_d[i] = rank_q[i];
			if (promote && (rank_q[i] < tgt_rank)) begin
				rank_d[i] = rank_q[i] + RW'(1);
			end
			if (demote && (rank_q[i] > tgt_rank)) begin
				rank_d[i] = rank_q[i] - RW'(1);
			end
		end
		if (promote) begin
			rank_d[tgt] = '0;
		end
		if (demote) begin
			rank_d[tgt] = LRU_RANK;
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_ready) begin
			s1_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			func_s1    <= func;
			address_s1 <= address;
			space_s1   <= addr_space;
			size_s1    <= page_size;
			ok_s1      <= fill_ok;
		end
	end

	// Slot and pending-miss state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				slot_base_q[i]  <= '0;
				slot_space_q[i] <= '0;
				slot_size_q[i]  <= '0;
				rank_q[i]       <= RW'(i);
			end
			pend_valid_q <= 1'b0;
			pend_slot_q  <= '0;
			pend_addr_q  <= '0;
		end else if (adv) begin
			for (int i = 0; i < SLOTS; i++) begin
				rank_q[i] <= rank_d[i];
			end
			if (size_clr) begin
				slot_size_q[tgt] <= '0;
			end
			if (slot_wr) begin
				slot_base_q[tgt]  <= address_s1;
				slot_space_q[tgt] <= space_s1;
				slot_size_q[tgt]  <= size_s1;
			end
			if (pend_set) begin
				pend_valid_q <= 1'b1;
				pend_slot_q  <= tgt;
				pend_addr_q  <= address_s1;
			end else if (pend_clr) begin
				pend_valid_q <= 1'b0;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && produce) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && produce) begin
			status_q         <= res_status;
			slot_index_q     <= 4'(res_idx);
			page_offset_q    <= res_off;
			release_needed_q <= res_rel;
			release_base_q   <= res_rbase;
			release_space_q  <= res_rspace;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = 3'(status_q);
	assign slot_index     = slot_index_q;
	assign page_offset    = page_offset_q;
	assign release_needed = release_needed_q;
	assign release_base   = release_base_q;
	assign release_space  = release_space_q;

	// Exactly one slot always holds the least recent rank.
	a_lru_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(lru_vec))
		else $error("recency ranks do not name exactly one least recent slot");

	// A lookup miss leaves a pending fill behind.
	a_miss_pends: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && pend_set) |=> pend_valid_q)
		else $error("miss did not leave a pending fill");

	// A held item that yields a result must block intake while the output stalls.
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && produce && out_valid_q && !out_ready) |-> !in_ready)
		else $error("input accepted while the result path is stalled");

endmodule
